>>> rtl/pum_pkg.sv
// Shared types, constants and the factorial table for the permutation unranker.
package pum_pkg;

    // Sizes
    localparam int MAX_LEN   = 12;
    localparam int LEN_W     = 4;
    localparam int RANK_W    = 29;
    localparam int FACT_W    = 26;
    localparam int MOM_W     = 16;
    localparam int BIT_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // Most significant rank bit, where each digit division starts
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(RANK_W - 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LENGTH      = 2'd0,
        REG_DIGITS_USED = 2'd1,
        REG_MOMENT_LOW  = 2'd2,
        REG_MOMENT_HIGH = 2'd3
    } cfg_reg_t;

    // Source of data written into the digit store
    typedef enum logic [1:0] {
        WSRC_ZERO = 2'd0,
        WSRC_MOD  = 2'd1,
        WSRC_ACC  = 2'd2
    } wsrc_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_DIV     = 4'd1,
        ST_ZERO    = 4'd2,
        ST_ADJ_RD  = 4'd3,
        ST_ADJ_ACC = 4'd4,
        ST_ADJ_CMP = 4'd5,
        ST_ADJ_WR  = 4'd6,
        ST_OUT_RD  = 4'd7,
        ST_OUT_LD  = 4'd8
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic              load_rank;
        logic              div_clear;
        logic              div_step;
        logic [BIT_W-1:0]  bit_idx;
        logic [LEN_W-1:0]  k;
        logic              ram_we;
        wsrc_t             wsrc;
        logic [LEN_W-1:0]  waddr;
        logic [LEN_W-1:0]  raddr;
        logic              acc_load;
        logic              acc_cmp;
        logic              out_load;
        logic              out_last;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [LEN_W-1:0] len_eff;
        logic [LEN_W-1:0] used_eff;
        logic             out_free;
    } sts_t;

    // n! for n = 0..MAX_LEN-1
    function automatic logic [FACT_W-1:0] fact(input logic [LEN_W-1:0] n);
        logic [FACT_W-1:0] f;
        unique case (n)
            4'd0:    f = FACT_W'(1);
            4'd1:    f = FACT_W'(1);
            4'd2:    f = FACT_W'(2);
            4'd3:    f = FACT_W'(6);
            4'd4:    f = FACT_W'(24);
            4'd5:    f = FACT_W'(120);
            4'd6:    f = FACT_W'(720);
            4'd7:    f = FACT_W'(5040);
            4'd8:    f = FACT_W'(40320);
            4'd9:    f = FACT_W'(362880);
            4'd10:   f = FACT_W'(3628800);
            4'd11:   f = FACT_W'(39916800);
            default: f = FACT_W'(1);
        endcase
        return f;
    endfunction

endpackage

>>> rtl/permutation_unrank_moments.sv
// Top level of the permutation unranker with per-element moments.
//
// Input channel: rank with in_valid/in_stall; a request is taken when in_valid
// is high and in_stall low. in_stall is low only while the block is idle.
// Output channel: element, moment, last_position with out_valid/out_stall;
// one result per position, in order, last_position set on the final one.
// Configuration: cfg_we writes cfg_data into register cfg_index (length,
// digits_used, moment_low, moment_high); write only while idle.
// A request runs through the digit division, the readjust scan and result
// delivery in turn. The digit phase uses the one-bit-per-cycle divider,
// the readjust one compare per cycle against the single-read-port digit
// store.
// Reset clears the controller to idle, empties the output register and
// loads the configuration reset values. A stalled receiver holds the
// current result; the block waits in delivery until it is taken, and a
// new request is accepted as soon as the last result sits in the output
// register.
module permutation_unrank_moments (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pum_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pum_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [pum_pkg::RANK_W-1:0]        rank,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pum_pkg::LEN_W-1:0]         element,
    output logic signed [pum_pkg::MOM_W-1:0]  moment,
    output logic                              last_position
);
    import pum_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pum_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    pum_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rank          (rank),
        .cmd           (cmd),
        .sts           (sts),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .element       (element),
        .moment        (moment),
        .last_position (last_position)
    );

endmodule

>>> rtl/pum_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pum_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 12
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pum_dpath.sv
// Datapath: config registers, bit-serial divider with modulo fold, digit store, output register.
module pum_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pum_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pum_pkg::CFG_W-1:0]         cfg_data,
    input  logic [pum_pkg::RANK_W-1:0]        rank,
    input  pum_pkg::cmd_t                     cmd,
    output pum_pkg::sts_t                     sts,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [pum_pkg::LEN_W-1:0]         element,
    output logic signed [pum_pkg::MOM_W-1:0]  moment,
    output logic                              last_position
);
    import pum_pkg::*;

    logic [LEN_W-1:0]        length_reg;
    logic [LEN_W-1:0]        digits_reg;
    logic signed [MOM_W-1:0] mom_low_reg;
    logic signed [MOM_W-1:0] mom_high_reg;

    logic [LEN_W-1:0]        len_eff;
    logic [LEN_W-1:0]        used_eff;
    logic [LEN_W-1:0]        half;

    logic [RANK_W-1:0]       rank_reg;
    logic [FACT_W-1:0]       rem_reg;
    logic [FACT_W-1:0]       rem_next;
    logic [LEN_W-1:0]        mod_reg;
    logic [LEN_W-1:0]        mod_next;
    logic [LEN_W-1:0]        acc_reg;

    logic [LEN_W-1:0]        fact_idx;
    logic [FACT_W:0]         divisor;
    logic [FACT_W:0]         trial;
    logic [FACT_W:0]         diff;
    logic                    qbit;
    logic [LEN_W-1:0]        modulus;
    logic [LEN_W:0]          mod_trial;
    logic [LEN_W:0]          mod_diff;

    logic [LEN_W-1:0]        ram_wdata;
    logic [LEN_W-1:0]        ram_rdata;

    logic                    out_valid_reg;
    logic [LEN_W-1:0]        element_reg;
    logic signed [MOM_W-1:0] moment_reg;
    logic                    last_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= LEN_W'(MAX_LEN);
            digits_reg   <= LEN_W'(MAX_LEN);
            mom_low_reg  <= '0;
            mom_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LENGTH:      length_reg   <= cfg_data[LEN_W-1:0];
                REG_DIGITS_USED: digits_reg   <= cfg_data[LEN_W-1:0];
                REG_MOMENT_LOW:  mom_low_reg  <= cfg_data[MOM_W-1:0];
                REG_MOMENT_HIGH: mom_high_reg <= cfg_data[MOM_W-1:0];
            endcase
        end
    end

    // Effective length and digit count
    always_comb
    begin
        if (length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (length_reg > LEN_W'(MAX_LEN))
        begin
            len_eff = LEN_W'(MAX_LEN);
        end
        else
        begin
            len_eff = length_reg;
        end
        used_eff = (digits_reg > len_eff) ? len_eff : digits_reg;
        half     = len_eff >> 1;
    end

    assign sts.len_eff  = len_eff;
    assign sts.used_eff = used_eff;
    assign sts.out_free = !out_valid_reg || !out_stall;

    // Restoring division step, quotient bits folded into a running modulo
    assign fact_idx  = used_eff - LEN_W'(1) - cmd.k;
    assign divisor   = {1'b0, fact(fact_idx)};
    assign trial     = {rem_reg, rank_reg[cmd.bit_idx]};
    assign diff      = trial - divisor;
    assign qbit      = (trial >= divisor);
    assign rem_next  = qbit ? diff[FACT_W-1:0] : trial[FACT_W-1:0];
    assign modulus   = len_eff - cmd.k;
    assign mod_trial = {mod_reg, qbit};
    assign mod_diff  = mod_trial - {1'b0, modulus};
    assign mod_next  = (mod_trial >= {1'b0, modulus}) ? mod_diff[LEN_W-1:0]
                                                      : mod_trial[LEN_W-1:0];

    // Rank and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_rank)
        begin
            rank_reg <= rank;
        end
        if (cmd.div_clear)
        begin
            rem_reg <= '0;
            mod_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            mod_reg <= mod_next;
        end
    end

    // Readjust accumulator: holds digit[p] while scanning lower positions
    always_ff @(posedge clk)
    begin
        if (cmd.acc_load)
        begin
            acc_reg <= ram_rdata;
        end
        else if (cmd.acc_cmp && (ram_rdata <= acc_reg))
        begin
            acc_reg <= acc_reg + LEN_W'(1);
        end
    end

    // Digit store write data
    always_comb
    begin
        unique case (cmd.wsrc)
            WSRC_ZERO: ram_wdata = '0;
            WSRC_MOD:  ram_wdata = mod_next;
            WSRC_ACC:  ram_wdata = acc_reg;
            default:   ram_wdata = '0;
        endcase
    end

    pum_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_LEN)
    ) u_digits (
        .clk   (clk),
        .we    (cmd.ram_we),
        .waddr (cmd.waddr),
        .wdata (ram_wdata),
        .raddr (cmd.raddr),
        .rdata (ram_rdata)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            element_reg <= ram_rdata;
            moment_reg  <= (ram_rdata < half) ? mom_low_reg : mom_high_reg;
            last_reg    <= cmd.out_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign element       = element_reg;
    assign moment        = moment_reg;
    assign last_position = last_reg;

endmodule

>>> rtl/pum_ctrl.sv
// Controller: sequences digit division, readjust scan and result delivery.
module pum_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  pum_pkg::sts_t  sts,
    output pum_pkg::cmd_t  cmd
);
    import pum_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [LEN_W-1:0] k_reg;
    logic [LEN_W-1:0] k_next;
    logic [BIT_W-1:0] bit_reg;
    logic [BIT_W-1:0] bit_next;
    logic [LEN_W-1:0] p_reg;
    logic [LEN_W-1:0] p_next;
    logic [LEN_W-1:0] q_reg;
    logic [LEN_W-1:0] q_next;
    logic [LEN_W-1:0] len_m1;
    logic [LEN_W-1:0] k_inc;

    assign len_m1 = sts.len_eff - LEN_W'(1);
    assign k_inc  = k_reg + LEN_W'(1);

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            bit_reg   <= '0;
            p_reg     <= '0;
            q_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            bit_reg   <= bit_next;
            p_reg     <= p_next;
            q_reg     <= q_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        bit_next   = bit_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    k_next     = '0;
                    bit_next   = BIT_LAST;
                    state_next = (sts.used_eff == '0) ? ST_ZERO : ST_DIV;
                end
            end
            ST_DIV, ST_ZERO:
            begin
                if ((state_reg == ST_ZERO) || (bit_reg == '0))
                begin
                    if (k_reg == len_m1)
                    begin
                        // all digits stored; a single position needs no readjust
                        if (len_m1 == '0)
                        begin
                            k_next     = '0;
                            state_next = ST_OUT_RD;
                        end
                        else
                        begin
                            p_next     = len_m1;
                            state_next = ST_ADJ_RD;
                        end
                    end
                    else
                    begin
                        k_next     = k_inc;
                        bit_next   = BIT_LAST;
                        state_next = (k_inc < sts.used_eff) ? ST_DIV : ST_ZERO;
                    end
                end
                else
                begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            ST_ADJ_RD:
            begin
                q_next     = p_reg - LEN_W'(1);
                state_next = ST_ADJ_ACC;
            end
            ST_ADJ_ACC:
            begin
                state_next = ST_ADJ_CMP;
            end
            ST_ADJ_CMP:
            begin
                if (q_reg == '0)
                begin
                    state_next = ST_ADJ_WR;
                end
                else
                begin
                    q_next = q_reg - LEN_W'(1);
                end
            end
            ST_ADJ_WR:
            begin
                if (p_reg == LEN_W'(1))
                begin
                    k_next     = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    p_next     = p_reg - LEN_W'(1);
                    state_next = ST_ADJ_RD;
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                if (sts.out_free)
                begin
                    if (k_reg == len_m1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_inc;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.load_rank = in_valid;
                cmd.div_clear = in_valid;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.bit_idx  = bit_reg;
                cmd.k        = k_reg;
                if (bit_reg == '0)
                begin
                    // final quotient bit: store the digit, clear for the next one
                    cmd.ram_we    = 1'b1;
                    cmd.wsrc      = WSRC_MOD;
                    cmd.waddr     = k_reg;
                    cmd.div_clear = 1'b1;
                end
            end
            ST_ZERO:
            begin
                cmd.ram_we = 1'b1;
                cmd.wsrc   = WSRC_ZERO;
                cmd.waddr  = k_reg;
            end
            ST_ADJ_RD:
            begin
                cmd.raddr = p_reg;
            end
            ST_ADJ_ACC:
            begin
                cmd.acc_load = 1'b1;
                cmd.raddr    = q_reg;
            end
            ST_ADJ_CMP:
            begin
                cmd.acc_cmp = 1'b1;
                cmd.raddr   = (q_reg == '0) ? q_reg : (q_reg - LEN_W'(1));
            end
            ST_ADJ_WR:
            begin
                cmd.ram_we = 1'b1;
                cmd.wsrc   = WSRC_ACC;
                cmd.waddr  = p_reg;
            end
            ST_OUT_RD:
            begin
                cmd.raddr = k_reg;
            end
            ST_OUT_LD:
            begin
                cmd.raddr    = k_reg;
                cmd.out_load = sts.out_free;
                cmd.out_last = (k_reg == len_m1);
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/pum_checker.sv
// Port-level checker for the permutation unranker, bound to the top level.
module pum_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [pum_pkg::LEN_W-1:0]         element,
    input  logic signed [pum_pkg::MOM_W-1:0]  moment,
    input  logic                              last_position
);
    import pum_pkg::*;

    // A result held under stall stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A result held under stall keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(element) && $stable(moment)
                                   && $stable(last_position))
        else $error("stalled result changed");

    // A taken request makes the block busy in the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while previous one in progress");

    // Elements always lie below MAX_LEN, the largest permutation length
    a_element_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> element < LEN_W'(MAX_LEN))
        else $error("element out of range");

endmodule

bind permutation_unrank_moments pum_checker u_pum_checker (.*);

>>> tb/permutation_unrank_moments_tb.sv
// Self-checking testbench for the permutation unranker with per-position moments.
module permutation_unrank_moments_tb;
    import pum_pkg::*;

    localparam int TIMEOUT_CYCLES = 600000;
    localparam int HOLD_CYCLES    = 600;
    localparam int PHASE_REQUESTS = 15;

    // One expected output position
    typedef struct {
        logic [LEN_W-1:0] element;
        logic [MOM_W-1:0] moment;
        logic             last_pos;
    } position_t;

    // Mirrors the configuration registers and predicts the positions of each request
    class unrank_scoreboard;
        logic [LEN_W-1:0] length_reg;
        logic [LEN_W-1:0] digits_reg;
        logic [MOM_W-1:0] moment_low_reg;
        logic [MOM_W-1:0] moment_high_reg;
        position_t        expected_q[$];
        int               error_count;

        function new();
            length_reg      = 4'd12;
            digits_reg      = 4'd12;
            moment_low_reg  = '0;
            moment_high_reg = '0;
            error_count     = 0;
        endfunction

        static function longint unsigned factorial(int n);
            longint unsigned f;
            int t;
            f = 1;
            for (t = 2; t <= n; t++)
                f = f * longint'(t);
            return f;
        endfunction

        function void set_register(cfg_reg_t idx, logic [CFG_W-1:0] v);
            case (idx)
                REG_LENGTH:      length_reg      = v[LEN_W-1:0];
                REG_DIGITS_USED: digits_reg      = v[LEN_W-1:0];
                REG_MOMENT_LOW:  moment_low_reg  = v[MOM_W-1:0];
                REG_MOMENT_HIGH: moment_high_reg = v[MOM_W-1:0];
                default: ;
            endcase
        endfunction

        // Zero length acts as one, anything above the maximum saturates
        function int effective_length();
            if (length_reg == 0)
                return 1;
            if (length_reg > MAX_LEN)
                return MAX_LEN;
            return int'(length_reg);
        endfunction

        function void flag(string msg);
            if (error_count < 10)
                $display("%s", msg);
            error_count++;
        endfunction

        // Lehmer digits from the rank, then readjusted from the end into a permutation
        function void note_rank(logic [RANK_W-1:0] r);
            int code[MAX_LEN];
            int n, d, half, p, q;
            longint unsigned rr;
            position_t pos;
            n  = effective_length();
            d  = (int'(digits_reg) > n) ? n : int'(digits_reg);
            rr = longint'(r);
            for (p = 0; p < MAX_LEN; p++)
                code[p] = 0;
            for (p = 0; p < d; p++)
                code[p] = int'((rr / factorial(d - 1 - p)) % longint'(n - p));
            for (p = n - 1; p > 0; p--)
                for (q = p - 1; q >= 0; q--)
                    if (code[q] <= code[p])
                        code[p]++;
            half = n / 2;
            for (p = 0; p < n; p++) begin
                pos.element  = LEN_W'(code[p]);
                pos.moment   = (code[p] < half) ? moment_low_reg : moment_high_reg;
                pos.last_pos = (p == n - 1);
                expected_q.push_back(pos);
            end
        endfunction

        function void check_position(logic [LEN_W-1:0] el, logic [MOM_W-1:0] mom, logic lp);
            position_t want;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected result: element %0d moment %h last %b", el, mom, lp));
                return;
            end
            want = expected_q.pop_front();
            if (el !== want.element || mom !== want.moment || lp !== want.last_pos)
                flag($sformatf({"mismatch: expected element %0d moment %h last %b, ",
                                "got element %0d moment %h last %b"},
                               want.element, want.moment, want.last_pos, el, mom, lp));
        endfunction

        function void close_out();
            if (expected_q.size() != 0)
                flag($sformatf("%0d expected results never arrived", expected_q.size()));
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [RANK_W-1:0]       rank;
    logic                    out_valid;
    logic                    out_stall;
    logic [LEN_W-1:0]        element;
    logic signed [MOM_W-1:0] moment;
    logic                    last_position;

    unrank_scoreboard sb = new();
    int sender_idle_pct   = 38;
    int receiver_idle_pct = 38;
    int hold_request      = 0;

    permutation_unrank_moments u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rank          (rank),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .element       (element),
        .moment        (moment),
        .last_position (last_position)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.note_rank(rank);
            if (out_valid && !out_stall)
                sb.check_position(element, moment, last_position);
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= (receiver_idle_pct > 0) && ($urandom_range(99) < receiver_idle_pct);
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_rank(input logic [RANK_W-1:0] r);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rank     <= r;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop offering and wait until every predicted position has been seen
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.expected_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write all four registers on consecutive cycles; block must be idle
    task automatic apply_config(input logic [CFG_W-1:0] len_d, input logic [CFG_W-1:0] used_d,
                                input logic [CFG_W-1:0] lo_d, input logic [CFG_W-1:0] hi_d);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LENGTH;
        cfg_data  <= len_d;
        sb.set_register(REG_LENGTH, len_d);
        @(posedge clk);
        cfg_index <= REG_DIGITS_USED;
        cfg_data  <= used_d;
        sb.set_register(REG_DIGITS_USED, used_d);
        @(posedge clk);
        cfg_index <= REG_MOMENT_LOW;
        cfg_data  <= lo_d;
        sb.set_register(REG_MOMENT_LOW, lo_d);
        @(posedge clk);
        cfg_index <= REG_MOMENT_HIGH;
        cfg_data  <= hi_d;
        sb.set_register(REG_MOMENT_HIGH, hi_d);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [MOM_W-1:0] pick_moment();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return MOM_W'($urandom);
        endcase
    endfunction

    // Random settings; unused upper data bits are randomized too
    task automatic random_config();
        logic [CFG_W-1:0] len_d;
        logic [CFG_W-1:0] used_d;
        len_d  = CFG_W'($urandom);
        used_d = CFG_W'($urandom);
        if ($urandom_range(3) == 0)
            len_d[LEN_W-1:0] = 4'd12;
        if ($urandom_range(3) == 0)
            used_d[LEN_W-1:0] = 4'd15;
        apply_config(len_d, used_d, pick_moment(), pick_moment());
    endtask

    // Half the ranks lie below L!, the rest anywhere in the field
    function automatic logic [RANK_W-1:0] pick_rank();
        longint unsigned span;
        span = unrank_scoreboard::factorial(sb.effective_length());
        if ($urandom_range(1))
            return RANK_W'($urandom_range(0, int'(span - 1)));
        return RANK_W'($urandom);
    endfunction

    // Main sequence
    initial
    begin
        int phase, i;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_LENGTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        rank      <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: full length, zero moments
        send_rank(29'd0);
        send_rank(29'd479001599);
        drain();

        // Full length, extreme moments, ranks at and past 12!
        apply_config(16'd12, 16'd12, 16'h7FFF, 16'h8000);
        send_rank(29'd1);
        send_rank(29'd479001600);
        send_rank(29'h1FFFFFFF);
        send_rank(29'h0AAAAAAA);
        send_rank(29'h15555555);
        drain();

        // Length one: single element takes the high moment
        apply_config(16'd1, 16'd12, 16'h0100, 16'hFF00);
        send_rank(29'd0);
        send_rank(29'h1FFFFFFF);
        drain();

        // Length zero behaves as one
        apply_config(16'd0, 16'd5, 16'h8000, 16'h7FFF);
        send_rank(29'd7);
        drain();

        // Length above max saturates; zero digits give the identity
        apply_config(16'd15, 16'd0, 16'h0080, 16'hFF80);
        send_rank(29'd12345);
        drain();

        // Digit count above length is clamped; rank past 4! wraps
        apply_config(16'd4, 16'd15, 16'h1234, 16'hEDCB);
        send_rank(29'd0);
        send_rank(29'd23);
        send_rank(29'd24);
        drain();

        apply_config(16'd2, 16'd2, 16'h0001, 16'hFFFF);
        send_rank(29'd0);
        send_rank(29'd1);
        drain();

        // Fewer digits than positions
        apply_config(16'd7, 16'd3, 16'h5A5A, 16'hA5A5);
        send_rank(pick_rank());
        send_rank(pick_rank());
        drain();

        // Random phases: one without idling, one with a long receiver hold-off
        for (phase = 0; phase < 6; phase++) begin
            random_config();
            sender_idle_pct   = (phase == 2) ? 0 : 38;
            receiver_idle_pct = (phase == 2) ? 0 : 38;
            if (phase == 4)
                hold_request = HOLD_CYCLES;
            for (i = 0; i < PHASE_REQUESTS; i++)
                send_rank(pick_rank());
            drain();
        end

        repeat (50) @(posedge clk);
        sb.close_out();
        if (sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * 8);
        $display("timeout after %0d cycles", TIMEOUT_CYCLES);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
rtl/pum_pkg.sv
rtl/pum_ram.sv
rtl/pum_dpath.sv
rtl/pum_ctrl.sv
rtl/permutation_unrank_moments.sv
rtl/pum_checker.sv
tb/permutation_unrank_moments_tb.sv
